// ===== rtl/mep_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time pixel unit.
package mep_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int IDX_W     = 10;
  localparam int FRAC_BITS = 26;
  localparam int C_W       = 43;  // width of c = origin + step*index
  localparam int Z_W       = 44;  // width of the iterate registers
  localparam int OP_W      = 30;  // multiplier operand width once |z| <= 4.0
  localparam int PROD_W    = 2 * OP_W;
  localparam int SQ_W      = 57;  // a square is at most 2^56
  localparam int ITER_W    = 16;
  localparam int SHADE_W   = 8;
  localparam int QDEPTH    = 2;

  localparam logic signed [31:0] ORIGIN_RE_RST = -32'sd142606336;
  localparam logic signed [31:0] ORIGIN_IM_RST = -32'sd100663296;
  localparam logic [30:0]        STEP_RST      = 31'd251658;
  localparam logic [ITER_W-1:0]  MAX_ITER_RST  = 16'd1024;

  typedef enum logic [1:0] {
    CFG_ORIGIN_RE,
    CFG_ORIGIN_IM,
    CFG_STEP,
    CFG_MAX_ITER
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        step;
    logic [ITER_W-1:0]  max_iter;
  } cfg_t;

  typedef struct packed {
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
  } point_t;

  // Clamp a pixel index to the image.
  function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    if (int'(v) >= MAX_DIM) begin
      r = IDX_W'(MAX_DIM - 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/mep_front.sv =====
// Front end: accepts a pixel beat and forms its point c.
module mep_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mep_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mep_pkg::IDX_W-1:0]  row_i,
  input  logic [mep_pkg::IDX_W-1:0]  col_i,
  output logic                       push_o,
  input  logic                       q_ready_i,
  output mep_pkg::point_t            point_o
);

  logic                           valid_q, valid_d;
  mep_pkg::point_t                point_q, point_d;
  logic [mep_pkg::IDX_W-1:0]      row_sat, col_sat;
  logic [30+mep_pkg::IDX_W:0]     prod_re, prod_im;
  logic                           accept;

  assign in_stall_o = valid_q && !q_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && q_ready_i;
  assign point_o    = point_q;

  always_comb begin
    row_sat = mep_pkg::sat_idx(row_i);
    col_sat = mep_pkg::sat_idx(col_i);
    prod_re = (31 + mep_pkg::IDX_W)'(cfg_i.step) * (31 + mep_pkg::IDX_W)'(col_sat);
    prod_im = (31 + mep_pkg::IDX_W)'(cfg_i.step) * (31 + mep_pkg::IDX_W)'(row_sat);
    point_d.re = mep_pkg::C_W'(cfg_i.origin_re) + $signed(mep_pkg::C_W'(prod_re));
    point_d.im = mep_pkg::C_W'(cfg_i.origin_im) + $signed(mep_pkg::C_W'(prod_im));
    valid_d = accept ? 1'b1 : (push_o ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      point_q <= point_d;
    end
  end

endmodule

// ===== rtl/mep_queue.sv =====
// Two-entry queue of points between front end and iteration engine.
module mep_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mep_pkg::point_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_i,
  output mep_pkg::point_t data_o
);

  localparam int PTR_W = $clog2(mep_pkg::QDEPTH);

  mep_pkg::point_t    mem_q [mep_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     count_q;
  logic               do_push, do_pop;

  assign ready_o = (count_q != (PTR_W + 1)'(mep_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/mep_iter.sv =====
// Back end: escape-time iteration on one shared multiplier, shade divide, result register.
module mep_iter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mep_pkg::cfg_t                 cfg_i,
  input  logic                          q_valid_i,
  input  mep_pkg::point_t               q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mep_pkg::SHADE_W-1:0]   shade_o,
  output logic [mep_pkg::ITER_W-1:0]    iter_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_CROSS,
    ST_UPD,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int REM_W = mep_pkg::ITER_W + mep_pkg::SHADE_W;
  localparam int DIV_W = mep_pkg::ITER_W + mep_pkg::SHADE_W - 1;
  localparam logic signed [mep_pkg::Z_W-1:0] FAR_POS = mep_pkg::Z_W'(64'sd1 << 28);
  localparam logic signed [mep_pkg::Z_W-1:0] FAR_NEG = -FAR_POS;
  localparam logic [mep_pkg::SQ_W:0] FOUR_Q52 = (mep_pkg::SQ_W + 1)'(64'd1 << 54);

  state_e                               state_q;
  mep_pkg::point_t                      pt_q;
  logic signed [mep_pkg::Z_W-1:0]       a_q, b_q, a_next, b_next;
  logic [mep_pkg::ITER_W-1:0]           k_q;
  logic signed [mep_pkg::OP_W-1:0]      op_x, op_y;
  logic signed [mep_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic [mep_pkg::SQ_W-1:0]             aa_q, bb_q;
  logic [mep_pkg::SQ_W:0]               sq_sum;
  logic signed [mep_pkg::SQ_W:0]        sq_diff;
  logic                                 far, escape, load_out, ge;
  logic [REM_W-1:0]                     rem_q;
  logic [DIV_W-1:0]                     div_q;
  logic [mep_pkg::SHADE_W-1:0]          quo_q;
  logic [2:0]                           cnt_q;

  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_o || !out_stall_i);

  always_comb begin
    case (state_q)
      ST_SQ_A: begin
        op_x = a_q[mep_pkg::OP_W-1:0];
        op_y = a_q[mep_pkg::OP_W-1:0];
      end
      ST_SQ_B: begin
        op_x = b_q[mep_pkg::OP_W-1:0];
        op_y = b_q[mep_pkg::OP_W-1:0];
      end
      default: begin
        op_x = a_q[mep_pkg::OP_W-1:0];
        op_y = b_q[mep_pkg::OP_W-1:0];
      end
    endcase
    prod_d = mep_pkg::PROD_W'(op_x) * mep_pkg::PROD_W'(op_y);

    far = (a_q > FAR_POS) || (a_q < FAR_NEG) || (b_q > FAR_POS) || (b_q < FAR_NEG);
    // in CROSS prod_q holds b*b
    sq_sum  = {1'b0, aa_q} + {1'b0, prod_q[mep_pkg::SQ_W-1:0]};
    escape  = sq_sum > FOUR_Q52;
    sq_diff = $signed({1'b0, aa_q}) - $signed({1'b0, bb_q});
    // arithmetic shift is floor; 2ab >> 26 is ab >> 25
    a_next  = mep_pkg::Z_W'($signed(sq_diff[mep_pkg::SQ_W:mep_pkg::FRAC_BITS]))
            + mep_pkg::Z_W'(pt_q.re);
    b_next  = mep_pkg::Z_W'($signed(prod_q[mep_pkg::SQ_W:mep_pkg::FRAC_BITS-1]))
            + mep_pkg::Z_W'(pt_q.im);
    ge      = (div_q != '0) && (rem_q >= REM_W'(div_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_o  <= 1'b0;
      shade_o      <= '0;
      iter_count_o <= '0;
      pt_q         <= '0;
      a_q          <= '0;
      b_q          <= '0;
      k_q          <= '0;
      prod_q       <= '0;
      aa_q         <= '0;
      bb_q         <= '0;
      rem_q        <= '0;
      div_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
    end else begin
      prod_q <= prod_d;
      if (out_valid_o && !out_stall_i && !load_out) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            pt_q    <= q_data_i;
            a_q     <= mep_pkg::Z_W'(q_data_i.re);
            b_q     <= mep_pkg::Z_W'(q_data_i.im);
            k_q     <= '0;
            state_q <= ST_SQ_A;
          end
        end
        ST_SQ_A: begin
          if (k_q == cfg_i.max_iter || far) begin
            rem_q   <= {k_q, 8'b0} - REM_W'(k_q);
            div_q   <= {cfg_i.max_iter, 7'b0};
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_SQ_B;
          end
        end
        ST_SQ_B: begin
          aa_q    <= prod_q[mep_pkg::SQ_W-1:0];
          state_q <= ST_CROSS;
        end
        ST_CROSS: begin
          if (escape) begin
            rem_q   <= {k_q, 8'b0} - REM_W'(k_q);
            div_q   <= {cfg_i.max_iter, 7'b0};
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            bb_q    <= prod_q[mep_pkg::SQ_W-1:0];
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          a_q     <= a_next;
          b_q     <= b_next;
          k_q     <= k_q + 1'b1;
          state_q <= ST_SQ_A;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (ge) begin
            rem_q <= rem_q - REM_W'(div_q);
          end
          quo_q <= {quo_q[mep_pkg::SHADE_W-2:0], ge};
          div_q <= div_q >> 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd7) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid_o  <= 1'b1;
            shade_o      <= ~quo_q;
            iter_count_o <= k_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_time_pixel_unit.sv =====
// Top level of the Mandelbrot escape-time pixel unit: config registers and wiring.
//
// Input channel: in_valid_i / in_stall_o carry one pixel (row_i, col_i) per beat.
// Output channel: out_valid_o / out_stall_i carry one result (shade_o,
// iter_count_o) per input beat, in input order.
// Config channel: cfg_valid_i / cfg_ready_o write cfg_data_i to register
// cfg_index_i (0 origin_re, 1 origin_im, 2 step, 3 max_iter); ready is always high.
// Write registers only while the unit is idle.
// The front end forms c combinationally, registers it and hands it to a
// two-entry queue, so up to three pixels are held while the back end works.
// The back end runs each iteration as the steps a*a, b*b, a*b and update on a
// single shared 30x30 multiplier, and finishes with a restoring divide for the
// 8-bit shade. A run ends after max_iter iterations or when |z|^2 > 4; the back
// end takes a new pixel only once the last result is in the output register.
// A stalled result holds in the output register; the back end waits there, the
// queue fills, then in_stall_o rises.
// Reset loads the default view (origin -2.125 - 1.5i, step about 3/800,
// max_iter 1024) and empties the pipeline.
module mandelbrot_escape_time_pixel_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mep_pkg::IDX_W-1:0]     row_i,
  input  logic [mep_pkg::IDX_W-1:0]     col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mep_pkg::SHADE_W-1:0]   shade_o,
  output logic [mep_pkg::ITER_W-1:0]    iter_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  mep_pkg::cfg_t   cfg_q;
  mep_pkg::point_t front_point, q_point;
  logic            push, q_ready, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_re <= mep_pkg::ORIGIN_RE_RST;
      cfg_q.origin_im <= mep_pkg::ORIGIN_IM_RST;
      cfg_q.step      <= mep_pkg::STEP_RST;
      cfg_q.max_iter  <= mep_pkg::MAX_ITER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mep_pkg::cfg_idx_e'(cfg_index_i))
        mep_pkg::CFG_ORIGIN_RE: cfg_q.origin_re <= $signed(cfg_data_i);
        mep_pkg::CFG_ORIGIN_IM: cfg_q.origin_im <= $signed(cfg_data_i);
        mep_pkg::CFG_STEP:      cfg_q.step      <= cfg_data_i[30:0];
        mep_pkg::CFG_MAX_ITER:  cfg_q.max_iter  <= cfg_data_i[mep_pkg::ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mep_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .row_i      (row_i),
    .col_i      (col_i),
    .push_o     (push),
    .q_ready_i  (q_ready),
    .point_o    (front_point)
  );

  mep_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_point),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_point)
  );

  mep_iter u_iter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_point),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .shade_o      (shade_o),
    .iter_count_o (iter_count_o)
  );

`ifndef ASSERT_OFF
  // a pixel that escapes at once is always the brightest shade
  a_zero_iter_shade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (iter_count_o == '0) |-> (shade_o == 8'hFF))
    else $error("zero iterations must give full shade");

  // the front end only backs up while holding a freshly taken beat
  a_stall_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted beat");
`endif

endmodule
